FILE: src/gcab_pkg.sv
// Package for the glyph colorize and alpha blend pipeline: item types and constants.
package gcab_pkg;

    // Channel value of a fully opaque alpha
    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
    // Channel value of a fully transparent alpha
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    // Command codes
    localparam logic CMD_FILL  = 1'b0;
    localparam logic CMD_GLYPH = 1'b1;

    // Divider layout: 8 quotient bits, two per stage
    localparam int QUO_BITS       = 8;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = QUO_BITS / BITS_PER_STAGE;

    // Color channels per pixel (red, green, blue)
    localparam int NUM_CHAN = 3;

    // Input item
    typedef struct packed {
        logic        command;
        logic [31:0] dest_pixel;
        logic [31:0] glyph_pixel;
        logic [31:0] blend_color;
    } pixel_t;

    // Result item
    typedef struct packed {
        logic [31:0] out_pixel;
        logic        write_enable;
    } result_t;

endpackage

FILE: src/glyph_colorize_alpha_blend.sv
// Glyph colorize and non-premultiplied RGBA8888 "over" blend, eight-stage pipeline.
//
// Usage:
//   pixel channel : pixel_valid / pixel_stall / pixel. An item is taken at a
//     rising edge with pixel_valid high and pixel_stall low. Each item holds a
//     command (fill or glyph), the destination pixel, the atlas pixel and the
//     blend color, RGBA8888 with red in the top byte.
//   result channel: result_valid / result_stall / result. One result item per
//     input item, in order: the new pixel and its write enable.
//   One item per cycle is sustained while result_stall is low; stage 1
//     tints, stage 2 forms the blend weights, stage 3 the weighted products,
//     stage 4 the numerators, and the per-channel quotient is resolved by a
//     restoring divider, two bits a stage, over the last four stages.
//   Stall: each stage holds while the stage after it is full and cannot move,
//     and empty stages keep filling, so a stalled result never blocks bubbles
//     from being squeezed out. Nothing is lost or repeated.
//   Reset (rst_n low, asynchronous) empties the pipeline; no result is
//     pending after reset and the block is ready at once.
module glyph_colorize_alpha_blend
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pixel_valid,
    output logic              pixel_stall,
    input  gcab_pkg::pixel_t  pixel,
    output logic              result_valid,
    input  logic              result_stall,
    output gcab_pkg::result_t result
);

    localparam int NUM_STAGES = 4 + gcab_pkg::DIV_STAGES;

    // Stage 1: tinted source, alpha product pending
    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] src;
        logic        use_prod;
        logic [15:0] prod;
    } s1_t;

    // Stage 2: resolved source and blend weights
    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] src;
        logic        zero;
        logic        opaque;
        logic [15:0] ws;
        logic [15:0] wd;
    } s2_t;

    // Stage 3: weighted products per channel
    typedef struct packed {
        logic [31:0]                          dest;
        logic [31:0]                          src;
        logic                                 zero;
        logic                                 opaque;
        logic [15:0]                          den;
        logic [7:0]                           alpha;
        logic [gcab_pkg::NUM_CHAN-1:0][23:0]  ps;
        logic [gcab_pkg::NUM_CHAN-1:0][23:0]  pd;
    } s3_t;

    // Divider stages: partial remainder and quotient per channel
    typedef struct packed {
        logic [31:0]                                        dest;
        logic [31:0]                                        src;
        logic                                               zero;
        logic                                               opaque;
        logic [15:0]                                        den;
        logic [7:0]                                         alpha;
        logic [gcab_pkg::NUM_CHAN-1:0][23:0]                rem;
        logic [gcab_pkg::NUM_CHAN-1:0][gcab_pkg::QUO_BITS-1:0] quo;
    } dv_t;

    // floor(x / 255), exact for x up to 65279
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    // Two restoring division steps at shifts sh_hi and sh_hi-1
    function automatic logic [25:0] div_pair(input logic [23:0] rem,
                                             input logic [15:0] den,
                                             input logic [2:0]  sh_hi);
        logic [23:0] r;
        logic [23:0] dsh;
        logic [1:0]  q;
        r   = rem;
        dsh = 24'(den) << sh_hi;
        q[1] = (r >= dsh);
        if (q[1])
        begin
            r = r - dsh;
        end
        dsh = 24'(den) << (sh_hi - 3'd1);
        q[0] = (r >= dsh);
        if (q[0])
        begin
            r = r - dsh;
        end
        return {q, r};
    endfunction

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] en;

    s1_t                 s1_reg, s1_next;
    s2_t                 s2_reg, s2_next;
    s3_t                 s3_reg, s3_next;
    dv_t                 dv_reg  [gcab_pkg::DIV_STAGES];
    dv_t                 dv_next [gcab_pkg::DIV_STAGES];
    gcab_pkg::result_t   out_reg, out_next;

    // Per-stage load enables: a stage loads when empty or when it drains
    always_comb
    begin
        en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || !result_stall;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign pixel_stall  = !en[0];
    assign result_valid = vld_reg[NUM_STAGES-1];
    assign result       = out_reg;

    // Stage 1: glyph tint
    always_comb
    begin
        logic [7:0] ga;
        ga = pixel.glyph_pixel[7:0];
        s1_next.dest     = pixel.dest_pixel;
        s1_next.src      = pixel.blend_color;
        s1_next.prod     = 16'(pixel.blend_color[7:0]) * 16'(ga);
        s1_next.use_prod = 1'b0;
        if (pixel.command == gcab_pkg::CMD_GLYPH)
        begin
            if (ga == gcab_pkg::ALPHA_CLEAR)
            begin
                s1_next.src = pixel.glyph_pixel;
            end
            else if (ga != gcab_pkg::ALPHA_OPAQUE)
            begin
                s1_next.use_prod = 1'b1;
            end
        end
    end

    // Stage 2: source alpha and blend weights
    always_comb
    begin
        logic [7:0] as;
        as = s1_reg.use_prod ? div255(s1_reg.prod) : s1_reg.src[7:0];
        s2_next.dest   = s1_reg.dest;
        s2_next.src    = {s1_reg.src[31:8], as};
        s2_next.zero   = (as == gcab_pkg::ALPHA_CLEAR);
        s2_next.opaque = (as == gcab_pkg::ALPHA_OPAQUE);
        s2_next.ws     = {as, 8'h00} - 16'(as);
        s2_next.wd     = 16'(s1_reg.dest[7:0]) * 16'(gcab_pkg::ALPHA_OPAQUE - as);
    end

    // Stage 3: denominator, output alpha, weighted channel products
    always_comb
    begin
        s3_next.dest   = s2_reg.dest;
        s3_next.src    = s2_reg.src;
        s3_next.zero   = s2_reg.zero;
        s3_next.opaque = s2_reg.opaque;
        s3_next.den    = s2_reg.ws + s2_reg.wd;
        s3_next.alpha  = div255(s2_reg.ws + s2_reg.wd);
        for (int c = 0; c < gcab_pkg::NUM_CHAN; c++)
        begin
            s3_next.ps[c] = 24'(s2_reg.src[31-8*c -: 8]) * 24'(s2_reg.ws);
            s3_next.pd[c] = 24'(s2_reg.dest[31-8*c -: 8]) * 24'(s2_reg.wd);
        end
    end

    // Stage 4: channel numerators, divider entry
    always_comb
    begin
        dv_next[0].dest   = s3_reg.dest;
        dv_next[0].src    = s3_reg.src;
        dv_next[0].zero   = s3_reg.zero;
        dv_next[0].opaque = s3_reg.opaque;
        dv_next[0].den    = s3_reg.den;
        dv_next[0].alpha  = s3_reg.alpha;
        dv_next[0].quo    = '0;
        for (int c = 0; c < gcab_pkg::NUM_CHAN; c++)
        begin
            dv_next[0].rem[c] = s3_reg.ps[c] + s3_reg.pd[c];
        end
    end

    // Divider stages: two quotient bits each, most significant first
    for (genvar g = 0; g < gcab_pkg::DIV_STAGES - 1; g++)
    begin : g_div
        localparam int HI = gcab_pkg::QUO_BITS - 1 - gcab_pkg::BITS_PER_STAGE * g;
        always_comb
        begin
            logic [25:0] r;
            dv_next[g+1] = dv_reg[g];
            for (int c = 0; c < gcab_pkg::NUM_CHAN; c++)
            begin
                r = div_pair(dv_reg[g].rem[c], dv_reg[g].den, 3'(HI));
                dv_next[g+1].rem[c]           = r[23:0];
                dv_next[g+1].quo[c][HI -: 2]  = r[25:24];
            end
        end
    end

    // Last divider step and result select
    always_comb
    begin
        logic [25:0]                                          r;
        logic [gcab_pkg::NUM_CHAN-1:0][gcab_pkg::QUO_BITS-1:0] q;
        dv_t                                                  d;
        d = dv_reg[gcab_pkg::DIV_STAGES-1];
        q = d.quo;
        for (int c = 0; c < gcab_pkg::NUM_CHAN; c++)
        begin
            r = div_pair(d.rem[c], d.den, 3'(gcab_pkg::BITS_PER_STAGE - 1));
            q[c][1:0] = r[25:24];
        end
        if (d.zero)
        begin
            out_next.out_pixel    = d.dest;
            out_next.write_enable = 1'b0;
        end
        else if (d.opaque)
        begin
            out_next.out_pixel    = d.src;
            out_next.write_enable = 1'b1;
        end
        else
        begin
            out_next.out_pixel    = {q[0], q[1], q[2], d.alpha};
            out_next.write_enable = 1'b1;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= pixel_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_reg <= s1_next;
        end
        if (en[1])
        begin
            s2_reg <= s2_next;
        end
        if (en[2])
        begin
            s3_reg <= s3_next;
        end
        for (int g = 0; g < gcab_pkg::DIV_STAGES; g++)
        begin
            if (en[3+g])
            begin
                dv_reg[g] <= dv_next[g];
            end
        end
        if (en[NUM_STAGES-1])
        begin
            out_reg <= out_next;
        end
    end

endmodule

FILE: sim/glyph_colorize_alpha_blend_tb.sv
// Self-checking testbench for the glyph colorize and alpha blend pipeline.
module glyph_colorize_alpha_blend_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RESET_CYCLES   = 6;
    localparam int          PIPE_LATENCY   = 8;
    localparam int          DRAIN_CYCLES   = 4 * PIPE_LATENCY;
    localparam int          RANDOM_ITEMS   = 1300;
    localparam int          TIMEOUT_CYCLES = 200000;
    localparam int          HOLD_AT_ITEM   = 100;
    localparam int          HOLD_CYCLES    = 60;
    localparam int unsigned ALPHA_MAX      = 32'(gcab_pkg::ALPHA_OPAQUE);
    localparam int          N_DIRECTED     = 24;
    localparam logic        FILL           = gcab_pkg::CMD_FILL;
    localparam logic        GLYPH          = gcab_pkg::CMD_GLYPH;

    // One stimulus row; want_* are used only where known is set
    typedef struct {
        logic        cmd;
        logic [31:0] dest;
        logic [31:0] glyph;
        logic [31:0] color;
        bit          known;
        logic [31:0] want_pixel;
        logic        want_we;
    } stim_item_t;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

    // Directed rows: transparent and opaque sources, alpha extremes, atlas tinting
    stim_item_t directed_rows [N_DIRECTED] = '{
        '{FILL,  32'h12345678, 32'hffffffff, 32'haabbcc00, 1'b1, 32'h12345678, 1'b0},
        '{FILL,  32'h00000000, 32'h00000000, 32'h00000000, 1'b1, 32'h00000000, 1'b0},
        '{FILL,  32'hffffffff, 32'h00000000, 32'h00000000, 1'b1, 32'hffffffff, 1'b0},
        '{FILL,  32'h00000000, 32'hffffffff, 32'hffffffff, 1'b1, 32'hffffffff, 1'b1},
        '{FILL,  32'hffffffff, 32'h00000000, 32'h112233ff, 1'b1, 32'h112233ff, 1'b1},
        '{FILL,  32'h00000000, 32'h00000000, 32'hffffff01, 1'b1, 32'hffffff01, 1'b1},
        '{FILL,  32'hffffffff, 32'h00000000, 32'h000000fe, 1'b0, 32'h0, 1'b0},
        '{FILL,  32'h80808080, 32'h00000000, 32'hff00ff80, 1'b0, 32'h0, 1'b0},
        '{FILL,  32'ha5a5a5ff, 32'h00000000, 32'h5a5a5a01, 1'b0, 32'h0, 1'b0},
        '{FILL,  32'h00000000, 32'h00000000, 32'h00000001, 1'b1, 32'h00000001, 1'b1},
        '{GLYPH, 32'h12345678, 32'h000000ff, 32'hcafebaff, 1'b1, 32'hcafebaff, 1'b1},
        '{GLYPH, 32'h12345678, 32'hffffff00, 32'hcafebaff, 1'b1, 32'h12345678, 1'b0},
        '{GLYPH, 32'h87654321, 32'h000000ff, 32'hcafeba00, 1'b1, 32'h87654321, 1'b0},
        '{GLYPH, 32'h87654321, 32'h00000001, 32'hcafeba01, 1'b1, 32'h87654321, 1'b0},
        '{GLYPH, 32'h00000000, 32'hfffffffe, 32'h112233ff, 1'b0, 32'h0, 1'b0},
        '{GLYPH, 32'hffffffff, 32'h00000080, 32'h336699ff, 1'b0, 32'h0, 1'b0},
        '{GLYPH, 32'h00ff00ff, 32'h00000001, 32'hffffffff, 1'b0, 32'h0, 1'b0},
        '{GLYPH, 32'h00000000, 32'h00000001, 32'hffffffff, 1'b1, 32'hffffff01, 1'b1},
        '{GLYPH, 32'h40404040, 32'h7f7f7f7f, 32'hc0c0c0c0, 1'b0, 32'h0, 1'b0},
        '{FILL,  32'hffffff00, 32'hffffffff, 32'h000000ff, 1'b1, 32'h000000ff, 1'b1},
        '{GLYPH, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1, 32'hffffffff, 1'b1},
        '{GLYPH, 32'h00000000, 32'h00000000, 32'h00000000, 1'b1, 32'h00000000, 1'b0},
        '{FILL,  32'h01020304, 32'h00000000, 32'h0a0b0c7f, 1'b0, 32'h0, 1'b0},
        '{GLYPH, 32'h0a0b0cfe, 32'h123456c8, 32'h89abcdef, 1'b0, 32'h0, 1'b0}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              pixel_valid;
    logic              pixel_stall;
    gcab_pkg::pixel_t  pixel;
    logic              result_valid;
    logic              result_stall;
    gcab_pkg::result_t result;

    // Sideband traveling with each offered item: typed-in expectation, if any
    logic              pixel_known;
    gcab_pkg::result_t pixel_want;

    stim_item_t        pixel_items [$];
    gcab_pkg::result_t expected_results [$];
    gcab_pkg::result_t oldest_expected;
    int unsigned       accepted_count = 0;
    int unsigned       error_count = 0;
    int unsigned       cycle_count = 0;
    bit                inputs_done = 1'b0;

    glyph_colorize_alpha_blend uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #4 clk = ~clk;

    // Random RGBA with alpha biased toward clear, opaque and the values next to them
    function automatic logic [31:0] random_rgba();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 7))
            0:       v[7:0] = gcab_pkg::ALPHA_CLEAR;
            1:       v[7:0] = gcab_pkg::ALPHA_OPAQUE;
            2:       v[7:0] = 8'h01;
            3:       v[7:0] = 8'hfe;
            default: v[7:0] = 8'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    // Tint (glyph mode), then non-premultiplied "over" with exact integer division
    function automatic gcab_pkg::result_t blend_over(gcab_pkg::pixel_t p);
        logic [31:0]       src;
        int unsigned       sa;
        int unsigned       ws;
        int unsigned       wd;
        int unsigned       den;
        int unsigned       mixed;
        int unsigned       tinted_alpha;
        int                c;
        gcab_pkg::result_t r;
        src = p.blend_color;
        if (p.command == gcab_pkg::CMD_GLYPH)
        begin
            if (p.glyph_pixel[7:0] == gcab_pkg::ALPHA_CLEAR)
            begin
                src = p.glyph_pixel;
            end
            else if (p.glyph_pixel[7:0] != gcab_pkg::ALPHA_OPAQUE)
            begin
                tinted_alpha = (int'(p.blend_color[7:0]) * int'(p.glyph_pixel[7:0]))
                               / ALPHA_MAX;
                src[7:0] = tinted_alpha[7:0];
            end
        end
        sa = 32'(src[7:0]);
        r.out_pixel    = p.dest_pixel;
        r.write_enable = 1'b1;
        if (src[7:0] == gcab_pkg::ALPHA_CLEAR)
        begin
            r.write_enable = 1'b0;
        end
        else if (src[7:0] == gcab_pkg::ALPHA_OPAQUE)
        begin
            r.out_pixel = src;
        end
        else
        begin
            ws  = sa * ALPHA_MAX;
            wd  = int'(p.dest_pixel[7:0]) * (ALPHA_MAX - sa);
            den = ws + wd;
            for (c = 0; c < gcab_pkg::NUM_CHAN; c++)
            begin
                mixed = (int'(src[31 - 8*c -: 8]) * ws
                         + int'(p.dest_pixel[31 - 8*c -: 8]) * wd) / den;
                r.out_pixel[31 - 8*c -: 8] = mixed[7:0];
            end
            mixed = den / ALPHA_MAX;
            r.out_pixel[7:0] = mixed[7:0];
        end
        return r;
    endfunction

    // Monitor: record each accepted item, check each accepted result in order
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_valid && !pixel_stall)
            begin
                if (pixel_known)
                    expected_results.push_back(pixel_want);
                else
                    expected_results.push_back(blend_over(pixel));
                accepted_count++;
            end
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item with none pending: out_pixel %08h write_enable %0b",
                           result.out_pixel, result.write_enable);
                    error_count++;
                end
                else
                begin
                    oldest_expected = expected_results.pop_front();
                    if (result.out_pixel !== oldest_expected.out_pixel)
                    begin
                        $error("out_pixel: expected %08h, got %08h",
                               oldest_expected.out_pixel, result.out_pixel);
                        error_count++;
                    end
                    if (result.write_enable !== oldest_expected.write_enable)
                    begin
                        $error("write_enable: expected %0b, got %0b",
                               oldest_expected.write_enable, result.write_enable);
                        error_count++;
                    end
                end
            end
        end
    end

    // Sender: bursts of items with random gaps; a stalled item is held as is
    initial
    begin : pixel_sender
        int unsigned next_item;
        int unsigned burst_left;
        int unsigned gap_left;
        stim_item_t  row;
        pixel_valid = 1'b0;
        pixel       = '0;
        pixel_known = 1'b0;
        pixel_want  = '0;
        next_item   = 0;
        burst_left  = 0;
        gap_left    = 0;
        wait (rst_n);
        while (!inputs_done)
        begin
            @(posedge clk);
            if (pixel_valid && !pixel_stall)
                next_item++;
            if (!(pixel_valid && pixel_stall))
            begin
                if (next_item == pixel_items.size())
                begin
                    pixel_valid <= 1'b0;
                    inputs_done = 1'b1;
                end
                else if (gap_left > 0)
                begin
                    gap_left--;
                    pixel_valid <= 1'b0;
                end
                else
                begin
                    row = pixel_items[next_item];
                    pixel_valid <= 1'b1;
                    pixel       <= '{command: row.cmd, dest_pixel: row.dest,
                                     glyph_pixel: row.glyph, blend_color: row.color};
                    pixel_known <= row.known;
                    pixel_want  <= '{out_pixel: row.want_pixel, write_enable: row.want_we};
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // Receiver: stall modes in phases, plus one long hold-off to back up the pipeline
    initial
    begin : result_receiver
        stall_mode_t stall_mode;
        int unsigned phase_left;
        int unsigned hold_left;
        bit          held_off;
        logic        stall_next;
        result_stall = 1'b0;
        stall_mode   = STALL_NONE;
        phase_left   = 0;
        hold_left    = 0;
        held_off     = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_off && accepted_count >= HOLD_AT_ITEM)
            begin
                held_off  = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    stall_mode = stall_mode_t'($urandom_range(0, 3));
                    phase_left = $urandom_range(20, 120);
                end
                phase_left--;
                case (stall_mode)
                    STALL_NONE:  stall_next = 1'b0;
                    STALL_LIGHT: stall_next = ($urandom_range(0, 4) == 0);
                    STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
                    default:     stall_next = ~result_stall;
                endcase
            end
            result_stall <= stall_next;
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < TIMEOUT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Build the stimulus, reset, run to completion and report
    initial
    begin : main_sequence
        stim_item_t item;
        int         i;
        for (i = 0; i < N_DIRECTED; i++)
            pixel_items.push_back(directed_rows[i]);
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            item.cmd        = ($urandom_range(0, 1) == 1) ? GLYPH : FILL;
            item.dest       = random_rgba();
            item.glyph      = random_rgba();
            item.color      = random_rgba();
            item.known      = 1'b0;
            item.want_pixel = '0;
            item.want_we    = 1'b0;
            pixel_items.push_back(item);
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        wait (inputs_done);
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
src/gcab_pkg.sv
src/glyph_colorize_alpha_blend.sv
sim/glyph_colorize_alpha_blend_tb.sv
